[hw/rtl/mbe_pkg.sv]
// ----------------------------------------------------------------------------
// mbe_pkg: shared definitions for the escape-time pixel core
// Widths, register map, reset values and fixed-point constants used by the
// core, its divider and its checker.
// ----------------------------------------------------------------------------
package mbe_pkg;

  // Fixed-point format of points (signed Q4.28) and thresholds (unsigned Q3.28).
  localparam int FRAC_W  = 28;
  localparam int COORD_W = 32;
  localparam int ZOOM_W  = 31;
  localparam int THR_W   = 31;
  localparam int ITER_W  = 16;
  localparam int PIX_W   = 10;
  localparam int COLOR_W = 8;

  // Default frame size.
  localparam int DEF_FRAME_WIDTH  = 800;
  localparam int DEF_FRAME_HEIGHT = 600;

  // Shared multiplier: signed operands, full-width product.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Colour divider: sized for a numerator of 255 * k^3 and a denominator of limit^3.
  localparam int DIV_DEN_W = 3 * ITER_W;
  localparam int DIV_NUM_W = DIV_DEN_W + COLOR_W;

  // Configuration port.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_CENTER_REAL  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_IMAG  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ZOOM_STEP    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ITER     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE_THR   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BINARY_VIEW  = 3'd5;

  // Reset values of the registers.
  localparam logic signed [COORD_W-1:0] RST_CENTER_REAL = '0;
  localparam logic signed [COORD_W-1:0] RST_CENTER_IMAG = '0;
  localparam logic [ZOOM_W-1:0]         RST_ZOOM_STEP   = 31'd1342177;
  localparam logic [ITER_W-1:0]         RST_MAX_ITER    = 16'd20;
  localparam logic [THR_W-1:0]          RST_ESCAPE_THR  = 31'd1073741824;
  localparam logic                      RST_BINARY_VIEW = 1'b1;

  localparam logic [COLOR_W-1:0] COLOR_MAX = '1;

endpackage

[hw/rtl/mandelbrot_escape_pixel_core.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_core: escape-time count and shade for one pixel
// Maps a pixel to a point c, iterates z = z^2 + c on one shared multiplier
// and shades the pixel from the iteration count.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         in_valid / in_stall       pixel_col, pixel_row
//   result    out        out_valid / out_stall     iter_count, in_set, red,
//                                                  green, blue
//   config    in         APB (psel, penable, ...)  six registers at 4*index
//
// For each request the sequencer maps the pixel to c, then iterates (the single
// multiplier forms x*x, y*y and x*y in turn), then forms the colour products
// and runs two divides in turn, blue first and then red.
// A new request is taken only once the previous one has reached the output
// register, so one result may wait under out_stall while the next is worked.
// Reset is synchronous; it restores the view registers to their defaults and
// returns the sequencer and output register to idle.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_core
  import mbe_pkg::*;
#(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  // Request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      pixel_col,
  input  logic [PIX_W-1:0]      pixel_row,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ITER_W-1:0]     iter_count,
  output logic                  in_set,
  output logic [COLOR_W-1:0]    red,
  output logic [COLOR_W-1:0]    green,
  output logic [COLOR_W-1:0]    blue,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Pixel offset from the frame centre, signed.
  localparam int HALF_W   = FRAME_WIDTH / 2;
  localparam int HALF_H   = FRAME_HEIGHT / 2;
  localparam int HALF_MAX = (HALF_W > HALF_H) ? HALF_W : HALF_H;
  localparam int HALF_BW  = $clog2(HALF_MAX + 1);
  localparam int D_W      = ((HALF_BW > PIX_W) ? HALF_BW : PIX_W) + 1;
  // Mapped point before saturation.
  localparam int MAP_W    = ZOOM_W + D_W + 2;
  // Iterate: an un-escaped component fits FRAC_W+3 signed bits, the new
  // value before the escape check needs FRAC_W+7.
  localparam int OP_W     = FRAC_W + 3;
  localparam int Z_W      = FRAC_W + 7;
  localparam int SQ_W     = 2 * (OP_W - 1) + 1;
  localparam int XY_W     = SQ_W + 1;
  localparam int DF_W     = XY_W + 1;
  localparam int SUM_W    = SQ_W - FRAC_W + 1;
  localparam int KK_W     = 2 * ITER_W;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MAP_R  = 4'd1;
  localparam logic [3:0] ST_MAP_I  = 4'd2;
  localparam logic [3:0] ST_MAP_C  = 4'd3;
  localparam logic [3:0] ST_UPDATE = 4'd4;
  localparam logic [3:0] ST_SQX    = 4'd5;
  localparam logic [3:0] ST_SQY    = 4'd6;
  localparam logic [3:0] ST_XY     = 4'd7;
  localparam logic [3:0] ST_KK     = 4'd8;
  localparam logic [3:0] ST_K3     = 4'd9;
  localparam logic [3:0] ST_MM     = 4'd10;
  localparam logic [3:0] ST_M3     = 4'd11;
  localparam logic [3:0] ST_DIV_B  = 4'd12;
  localparam logic [3:0] ST_DIV_R  = 4'd13;
  localparam logic [3:0] ST_DONE   = 4'd14;

  // Configuration registers.
  logic signed [COORD_W-1:0] center_real;
  logic signed [COORD_W-1:0] center_imag;
  logic [ZOOM_W-1:0]         zoom_step;
  logic [ITER_W-1:0]         max_iterations;
  logic [THR_W-1:0]          escape_threshold;
  logic                      binary_view;

  // Working registers.
  logic [3:0]                state;
  logic [PIX_W-1:0]          col;
  logic [PIX_W-1:0]          row;
  logic signed [MAP_W-1:0]   pr;
  logic signed [COORD_W-1:0] cr;
  logic signed [COORD_W-1:0] ci;
  logic signed [Z_W-1:0]     zr;
  logic signed [Z_W-1:0]     zi;
  logic [SQ_W-1:0]           xx;
  logic [SQ_W-1:0]           yy;
  logic signed [XY_W-1:0]    xy;
  logic [ITER_W-1:0]         i;
  logic [ITER_W-1:0]         iter;
  logic [KK_W-1:0]           kk;
  logic [KK_W-1:0]           mm;
  logic [DIV_DEN_W-1:0]      k3;
  logic [DIV_DEN_W-1:0]      m3;
  logic [COLOR_W-1:0]        blue_q;
  logic [COLOR_W-1:0]        red_q;

  // Combinational signals.
  logic [ITER_W-1:0]         lim;
  logic [ITER_W-1:0]         k;
  logic                      set_w;
  logic                      out_free;
  logic                      cfg_wr;
  logic [REG_IDX_W-1:0]      reg_idx;
  logic signed [D_W-1:0]     d_col;
  logic signed [D_W-1:0]     d_row;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [MAP_W-1:0]   map_sum_r;
  logic signed [MAP_W-1:0]   map_sum_i;
  logic signed [DF_W-1:0]    sq_diff;
  logic signed [Z_W-1:0]     nx;
  logic signed [Z_W-1:0]     ny;
  logic                      big;
  logic [SUM_W-1:0]          mag;
  logic                      escaped;
  logic                      div_start;
  logic [DIV_NUM_W-1:0]      div_num;
  logic [DIV_DEN_W-1:0]      div_den;
  logic                      div_done;
  logic [COLOR_W-1:0]        div_q;

  // Clamp a mapped coordinate to the signed Q4.28 range.
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [MAP_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > $signed(MAP_W'({1'b0, {(COORD_W-1){1'b1}}}))) begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < $signed(MAP_W'($signed({1'b1, {(COORD_W-1){1'b0}}})))) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // Configuration port: writes in the access phase, reads by index.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_real      <= RST_CENTER_REAL;
      center_imag      <= RST_CENTER_IMAG;
      zoom_step        <= RST_ZOOM_STEP;
      max_iterations   <= RST_MAX_ITER;
      escape_threshold <= RST_ESCAPE_THR;
      binary_view      <= RST_BINARY_VIEW;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CENTER_REAL: center_real      <= pwdata[COORD_W-1:0];
        REG_CENTER_IMAG: center_imag      <= pwdata[COORD_W-1:0];
        REG_ZOOM_STEP:   zoom_step        <= pwdata[ZOOM_W-1:0];
        REG_MAX_ITER:    max_iterations   <= pwdata[ITER_W-1:0];
        REG_ESCAPE_THR:  escape_threshold <= pwdata[THR_W-1:0];
        REG_BINARY_VIEW: binary_view      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CENTER_REAL: prdata = center_real;
      REG_CENTER_IMAG: prdata = center_imag;
      REG_ZOOM_STEP:   prdata = APB_DATA_W'(zoom_step);
      REG_MAX_ITER:    prdata = APB_DATA_W'(max_iterations);
      REG_ESCAPE_THR:  prdata = APB_DATA_W'(escape_threshold);
      REG_BINARY_VIEW: prdata = APB_DATA_W'(binary_view);
      default:         prdata = '0;
    endcase
  end

  // A limit of zero behaves as a limit of one.
  assign lim      = (max_iterations == '0) ? ITER_W'(1) : max_iterations;
  assign set_w    = (iter == lim);
  assign k        = (binary_view || set_w) ? iter : '0;
  assign out_free = !(out_valid && out_stall);
  assign in_stall = (state != ST_IDLE);

  // Pixel offsets from the frame centre.
  assign d_col = D_W'(col) - D_W'(HALF_W);
  assign d_row = D_W'(row) - D_W'(HALF_H);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MAP_R: begin
        mul_a = MUL_W'(zoom_step);
        mul_b = MUL_W'(d_col);
      end
      ST_MAP_I: begin
        mul_a = MUL_W'(zoom_step);
        mul_b = MUL_W'(d_row);
      end
      ST_SQX: begin
        mul_a = zr[MUL_W-1:0];
        mul_b = zr[MUL_W-1:0];
      end
      ST_SQY: begin
        mul_a = zi[MUL_W-1:0];
        mul_b = zi[MUL_W-1:0];
      end
      ST_XY: begin
        mul_a = zr[MUL_W-1:0];
        mul_b = zi[MUL_W-1:0];
      end
      ST_KK: begin
        mul_a = MUL_W'(k);
        mul_b = MUL_W'(k);
      end
      ST_K3: begin
        mul_a = MUL_W'(kk);
        mul_b = MUL_W'(k);
      end
      ST_MM: begin
        mul_a = MUL_W'(lim);
        mul_b = MUL_W'(lim);
      end
      ST_M3: begin
        mul_a = MUL_W'(mm);
        mul_b = MUL_W'(lim);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Mapping sums, before saturation.
  assign map_sum_r = MAP_W'(center_real) + pr;
  assign map_sum_i = MAP_W'(center_imag) + pr;

  // z update: floor((x^2 - y^2) / 2^28) + c_re and floor(2xy / 2^28) + c_im.
  assign sq_diff = $signed({2'b00, xx}) - $signed({2'b00, yy});
  assign nx      = $signed(sq_diff[DF_W-1:FRAC_W]) + Z_W'(cr);
  assign ny      = $signed(xy[XY_W-1:FRAC_W-1]) + Z_W'(ci);

  // A component of magnitude 4 or more has certainly escaped.
  assign big = (zr[Z_W-1:OP_W-1] != {(Z_W-OP_W+1){zr[OP_W-1]}}) ||
               (zi[Z_W-1:OP_W-1] != {(Z_W-OP_W+1){zi[OP_W-1]}});

  // Escape test on the truncated squares.
  assign mag     = SUM_W'(xx[SQ_W-1:FRAC_W]) + SUM_W'(yy[SQ_W-1:FRAC_W]);
  assign escaped = SUM_W'(escape_threshold) < mag;

  // Colour divides: blue first, red started as blue completes.
  assign div_start = (state == ST_M3) || ((state == ST_DIV_B) && div_done);
  always_comb begin
    if (state == ST_M3) begin
      div_num = DIV_NUM_W'({k, {COLOR_W{1'b0}}}) - DIV_NUM_W'(k);
      div_den = DIV_DEN_W'(lim);
    end else begin
      div_num = DIV_NUM_W'({k3, {COLOR_W{1'b0}}}) - DIV_NUM_W'(k3);
      div_den = m3;
    end
  end

  mbe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE:   if (in_valid) state <= ST_MAP_R;
        ST_MAP_R:  state <= ST_MAP_I;
        ST_MAP_I:  state <= ST_MAP_C;
        ST_MAP_C:  state <= (lim == ITER_W'(1)) ? ST_KK : ST_UPDATE;
        ST_UPDATE: state <= ST_SQX;
        ST_SQX:    state <= big ? ST_KK : ST_SQY;
        ST_SQY:    state <= ST_XY;
        ST_XY: begin
          if (escaped || (i == lim - 1'b1)) begin
            state <= ST_KK;
          end else begin
            state <= ST_UPDATE;
          end
        end
        ST_KK:     state <= ST_K3;
        ST_K3:     state <= ST_MM;
        ST_MM:     state <= ST_M3;
        ST_M3:     state <= ST_DIV_B;
        ST_DIV_B:  if (div_done) state <= ST_DIV_R;
        ST_DIV_R:  if (div_done) state <= ST_DONE;
        ST_DONE:   if (out_free) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          col <= pixel_col;
          row <= pixel_row;
        end
      end
      ST_MAP_R: pr <= mul_p[MAP_W-1:0];
      ST_MAP_I: begin
        cr <= sat_coord(map_sum_r);
        pr <= mul_p[MAP_W-1:0];
      end
      ST_MAP_C: begin
        ci   <= sat_coord(map_sum_i);
        i    <= ITER_W'(1);
        iter <= lim;
        xx   <= '0;
        yy   <= '0;
        xy   <= '0;
      end
      ST_UPDATE: begin
        zr <= nx;
        zi <= ny;
      end
      ST_SQX: begin
        if (big) begin
          iter <= i;
        end else begin
          xx <= mul_p[SQ_W-1:0];
        end
      end
      ST_SQY: yy <= mul_p[SQ_W-1:0];
      ST_XY: begin
        if (escaped) begin
          iter <= i;
        end else begin
          xy <= mul_p[XY_W-1:0];
          i  <= i + 1'b1;
        end
      end
      ST_KK:    kk <= mul_p[KK_W-1:0];
      ST_K3:    k3 <= mul_p[DIV_DEN_W-1:0];
      ST_MM:    mm <= mul_p[KK_W-1:0];
      ST_M3:    m3 <= mul_p[DIV_DEN_W-1:0];
      ST_DIV_B: if (div_done) blue_q <= div_q;
      ST_DIV_R: if (div_done) red_q <= div_q;
      default: ;
    endcase
  end

  // Output register: loaded once the previous result has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      iter_count <= iter;
      in_set     <= set_w;
      green      <= set_w ? COLOR_MAX : '0;
      blue       <= blue_q;
      red        <= red_q;
    end
  end

endmodule

[hw/rtl/mbe_div.sv]
// ----------------------------------------------------------------------------
// mbe_div: restoring divider for the colour channels
// Produces a COLOR_W-bit quotient, one bit per cycle, for a numerator known
// to be below 2^COLOR_W times the denominator.
// ----------------------------------------------------------------------------
module mbe_div
  import mbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [COLOR_W-1:0]   quot
);

  localparam int SH_W  = DIV_DEN_W + COLOR_W - 1;
  localparam int CMP_W = (DIV_NUM_W > SH_W) ? DIV_NUM_W : SH_W;
  localparam int CNT_W = (COLOR_W > 1) ? $clog2(COLOR_W) : 1;

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_NUM_W-1:0] rem;
  logic [SH_W-1:0]      dsh;
  logic                 ge;
  logic [CMP_W-1:0]     diff;

  // Trial subtraction of the shifted divisor.
  always_comb begin
    ge   = CMP_W'(rem) >= CMP_W'(dsh);
    diff = CMP_W'(rem) - CMP_W'(dsh);
  end

  // Sequencing: load on start, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder, shifted divisor and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= {den, {(COLOR_W-1){1'b0}}};
      cnt  <= CNT_W'(COLOR_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= diff[DIV_NUM_W-1:0];
      end
      dsh  <= dsh >> 1;
      cnt  <= cnt - 1'b1;
      quot <= {quot[COLOR_W-2:0], ge};
    end
  end

endmodule

[hw/rtl/mbe_checker.sv]
// ----------------------------------------------------------------------------
// mbe_checker: port-level checks for the escape-time pixel core
// Watches the request and result channels and checks the shading rules
// that the result must obey.
// ----------------------------------------------------------------------------
module mbe_checker
  import mbe_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [ITER_W-1:0]  iter_count,
  input logic               in_set,
  input logic [COLOR_W-1:0] red,
  input logic [COLOR_W-1:0] green,
  input logic [COLOR_W-1:0] blue
);

  // An accepted request keeps the core busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("core took a request without going busy");

  // Green marks exactly the points inside the set.
  a_green_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (in_set ? (green == COLOR_MAX) : (green == '0)))
    else $error("green does not match in_set");

  // A point inside the set reaches full blue and red.
  a_full_shade: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_set |-> (blue == COLOR_MAX) && (red == COLOR_MAX))
    else $error("in-set point not fully shaded");

  // A stalled result stays put.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(iter_count) && $stable(in_set) &&
      $stable(red) && $stable(green) && $stable(blue))
    else $error("stalled result changed");

endmodule

bind mandelbrot_escape_pixel_core mbe_checker u_mbe_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .iter_count (iter_count),
  .in_set     (in_set),
  .red        (red),
  .green      (green),
  .blue       (blue)
);

[sim/tb_mandelbrot_escape_pixel_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_pixel_core: self-checking bench for the escape-time core
// Sends pixel requests and keeps its own fixed-point model of the view. The
// model predicts iteration count, set membership and shade for each request.
// Every result is checked in order against that prediction. Short directed
// tests cover the limits of the view registers. Random views follow, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_pixel_core;
  import mbe_pkg::*;

  localparam int     HALF_W        = DEF_FRAME_WIDTH / 2;
  localparam int     HALF_H        = DEF_FRAME_HEIGHT / 2;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     TAIL_CYCLES   = 300;
  localparam int     CYCLE_LIMIT   = 4_000_000;
  localparam int     RANDOM_PHASES = 9;
  localparam int     PHASE_PIXELS  = 55;
  localparam longint Q_MAX         = 64'sd2147483647;
  localparam longint Q_MIN         = -64'sd2147483648;

  // Fixed-point values used by the directed tests (Q4.28).
  localparam logic [31:0] Q_ONE       = 32'h1000_0000;
  localparam logic [31:0] Q_FOUR      = 32'h4000_0000;
  localparam logic [31:0] Q_MINUS_HALF = 32'hF800_0000;

  typedef struct packed {
    logic [ITER_W-1:0]  count;
    logic               member;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } shade_t;

  // DUT signals
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      pixel_col = '0;
  logic [PIX_W-1:0]      pixel_row = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ITER_W-1:0]     iter_count;
  logic                  in_set;
  logic [COLOR_W-1:0]    red;
  logic [COLOR_W-1:0]    green;
  logic [COLOR_W-1:0]    blue;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Copy of the view registers as the bench has written them.
  logic signed [COORD_W-1:0] view_re       = RST_CENTER_REAL;
  logic signed [COORD_W-1:0] view_im       = RST_CENTER_IMAG;
  logic [ZOOM_W-1:0]         view_zoom     = RST_ZOOM_STEP;
  logic [ITER_W-1:0]         iter_limit    = RST_MAX_ITER;
  logic [THR_W-1:0]          escape_bound  = RST_ESCAPE_THR;
  logic                      shade_escapes = RST_BINARY_VIEW;

  shade_t expected_shades[$];
  shade_t want;
  int     pixels_sent    = 0;
  int     results_checked = 0;
  int     reg_writes     = 0;
  int     mismatches     = 0;
  int     cycle_cnt      = 0;
  int     stall_hold     = 0;
  int     stall_roll;
  bit     tx_gaps_on     = 1'b1;
  bit     rx_stall_on    = 1'b1;

  mandelbrot_escape_pixel_core uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_col  (pixel_col),
    .pixel_row  (pixel_row),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .iter_count (iter_count),
    .in_set     (in_set),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // Run-length guard.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $error("Timed out after %0d cycles with %0d results outstanding",
             cycle_cnt, expected_shades.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Point on one axis: centre plus zoom times offset from mid-frame, saturated.
  function automatic longint map_axis(input logic signed [COORD_W-1:0] ctr,
                                      input logic [PIX_W-1:0] pos, input int half);
    longint v;
    v = longint'(ctr) + longint'(view_zoom) * (longint'(pos) - half);
    if (v > Q_MAX) v = Q_MAX;
    if (v < Q_MIN) v = Q_MIN;
    return v;
  endfunction

  // Escape count and shade of one pixel under the current view.
  function automatic shade_t predict_shade(input logic [PIX_W-1:0] col,
                                           input logic [PIX_W-1:0] row);
    longint              limit, iter, k, i, bound;
    logic signed [127:0] cr, ci, x, y, nx, ny, mag;
    shade_t              s;
    limit = (iter_limit == '0) ? 64'sd1 : longint'(iter_limit);
    bound = longint'(escape_bound);
    cr    = 128'(map_axis(view_re, col, HALF_W));
    ci    = 128'(map_axis(view_im, row, HALF_H));
    x     = '0;
    y     = '0;
    iter  = limit;
    for (i = 1; i < limit; i++) begin
      // Arithmetic shift of the exact product floors towards minus infinity.
      nx = ((x * x - y * y) >>> FRAC_W) + cr;
      ny = ((2 * x * y) >>> FRAC_W) + ci;
      x  = nx;
      y  = ny;
      mag = ((x * x) >>> FRAC_W) + ((y * y) >>> FRAC_W);
      if (mag > bound) begin
        iter = i;
        break;
      end
    end
    s.count  = ITER_W'(iter);
    s.member = (iter == limit);
    // Escaped points go black when shading by count is off.
    k        = (shade_escapes || s.member) ? iter : 64'sd0;
    s.red    = COLOR_W'((255 * k * k * k) / (limit * limit * limit));
    s.green  = s.member ? COLOR_MAX : '0;
    s.blue   = COLOR_W'((255 * k) / limit);
    return s;
  endfunction

  // Result-side back-pressure: mostly short stalls, a few long ones.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (!rx_stall_on) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 55) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 6);
      end else if (stall_roll < 92) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(10, 40);
      end
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_shades.size() == 0) begin
        $error("Result with no request outstanding: iter_count %0d", iter_count);
        mismatches++;
      end else begin
        want = expected_shades.pop_front();
        if (iter_count !== want.count) begin
          $error("iter_count: expected %0d, got %0d", want.count, iter_count);
          mismatches++;
        end
        if (in_set !== want.member) begin
          $error("in_set: expected %0d, got %0d", want.member, in_set);
          mismatches++;
        end
        if (red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, red);
          mismatches++;
        end
        if (green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, green);
          mismatches++;
        end
        if (blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, blue);
          mismatches++;
        end
      end
      results_checked++;
    end
  end

  // Request-side gap length: often none, sometimes short, rarely long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Register write: setup phase, then access phase, then the bus returns to idle.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CENTER_REAL: view_re       = value;
      REG_CENTER_IMAG: view_im       = value;
      REG_ZOOM_STEP:   view_zoom     = value[ZOOM_W-1:0];
      REG_MAX_ITER:    iter_limit    = value[ITER_W-1:0];
      REG_ESCAPE_THR:  escape_bound  = value[THR_W-1:0];
      REG_BINARY_VIEW: shade_escapes = value[0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // Send one pixel request and record its predicted result once accepted.
  task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    pixel_col <= col;
    pixel_row <= row;
    do @(posedge clk); while (in_stall);
    expected_shades.push_back(predict_shade(col, row));
    pixels_sent++;
  endtask

  // Stop sending and wait until every predicted result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_shades.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reset view: set centre, frame corners and a pixel far outside the frame.
  task automatic test_default_view();
    drain_results();
    send_pixel(10'd400, 10'd300);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd799, 10'd599);
    send_pixel(10'd799, 10'd0);
    send_pixel(10'd0, 10'd599);
    send_pixel(10'd1023, 10'd1023);
  endtask

  // A limit of zero behaves as one; limits of one and two.
  task automatic test_iteration_limits();
    drain_results();
    write_reg(REG_MAX_ITER, 32'd0);
    send_pixel(10'd400, 10'd300);
    send_pixel(10'd0, 10'd0);
    drain_results();
    write_reg(REG_MAX_ITER, 32'd1);
    send_pixel(10'd400, 10'd300);
    send_pixel(10'd799, 10'd599);
    drain_results();
    write_reg(REG_MAX_ITER, 32'd2);
    send_pixel(10'd400, 10'd300);
    send_pixel(10'd600, 10'd300);
  endtask

  // Escaped points shade black when shading by count is off.
  task automatic test_black_escapes();
    drain_results();
    write_reg(REG_MAX_ITER, 32'd20);
    write_reg(REG_BINARY_VIEW, 32'd0);
    send_pixel(10'd400, 10'd300);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd250, 10'd180);
  endtask

  // Zero zoom, saturating points at the range ends, and both threshold ends.
  task automatic test_plane_extremes();
    drain_results();
    write_reg(REG_BINARY_VIEW, 32'd1);
    write_reg(REG_ZOOM_STEP, 32'd0);
    write_reg(REG_CENTER_REAL, Q_MINUS_HALF);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    drain_results();
    write_reg(REG_ZOOM_STEP, 32'h7FFF_FFFF);
    write_reg(REG_CENTER_REAL, 32'h8000_0000);
    write_reg(REG_CENTER_IMAG, 32'h7FFF_FFFF);
    write_reg(REG_ESCAPE_THR, 32'h7FFF_FFFF);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    drain_results();
    write_reg(REG_ESCAPE_THR, 32'd0);
    write_reg(REG_ZOOM_STEP, Q_ONE);
    write_reg(REG_CENTER_REAL, 32'd0);
    write_reg(REG_CENTER_IMAG, 32'd0);
    send_pixel(10'd400, 10'd300);
    send_pixel(10'd401, 10'd300);
  endtask

  // Largest limit: one point that never escapes, two that escape early.
  task automatic test_deep_limit();
    drain_results();
    write_reg(REG_ESCAPE_THR, Q_FOUR);
    write_reg(REG_ZOOM_STEP, 32'(RST_ZOOM_STEP));
    write_reg(REG_MAX_ITER, 32'd65535);
    send_pixel(10'd400, 10'd300);
    send_pixel(10'd799, 10'd599);
    send_pixel(10'd400, 10'd0);
  endtask

  // Random views: most frame the set, a few are arbitrary register values.
  task automatic test_random_views();
    int               phase, n, roll;
    logic [PIX_W-1:0] col, row;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      // The first phase runs back to back with no idling on either side.
      tx_gaps_on  = (phase != 0) && ($urandom_range(0, 3) != 0);
      rx_stall_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 9);
      if (phase == 0 || roll < 7) begin
        write_reg(REG_CENTER_REAL, $urandom_range(0, 32'h2800_0000) - 32'h2000_0000);
        write_reg(REG_CENTER_IMAG, $urandom_range(0, 32'h2800_0000) - 32'h1400_0000);
        write_reg(REG_ZOOM_STEP, $urandom_range(32'h100, 32'h40_0000));
        write_reg(REG_MAX_ITER, $urandom_range(1, 64));
        write_reg(REG_ESCAPE_THR,
                  ($urandom_range(0, 4) != 0) ? Q_FOUR : ($urandom() & 32'h7FFF_FFFF));
        write_reg(REG_BINARY_VIEW, $urandom_range(0, 1));
      end else begin
        write_reg(REG_CENTER_REAL, $urandom());
        write_reg(REG_CENTER_IMAG, $urandom());
        write_reg(REG_ZOOM_STEP, $urandom() & 32'h7FFF_FFFF);
        write_reg(REG_MAX_ITER, $urandom_range(0, 48));
        write_reg(REG_ESCAPE_THR, $urandom() & 32'h7FFF_FFFF);
        write_reg(REG_BINARY_VIEW, $urandom_range(0, 1));
      end
      for (n = 0; n < PHASE_PIXELS; n++) begin
        // Once in the run the sender holds off until the core is empty.
        if (phase == 2 && n == PHASE_PIXELS / 2) drain_results();
        if ($urandom_range(0, 99) < 85) begin
          col = PIX_W'($urandom_range(0, DEF_FRAME_WIDTH - 1));
          row = PIX_W'($urandom_range(0, DEF_FRAME_HEIGHT - 1));
        end else begin
          col = PIX_W'($urandom_range(0, 1023));
          row = PIX_W'($urandom_range(0, 1023));
        end
        send_pixel(col, row);
      end
    end
  endtask

  // Test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_view();
    test_iteration_limits();
    test_black_escapes();
    test_plane_extremes();
    test_deep_limit();
    test_random_views();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d results from %0d pixel requests across %0d register writes,",
             results_checked, pixels_sent, reg_writes);
    $display("including limit, zoom, saturation and threshold extremes; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
